### rtl/core/jfhc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// JPEG frame header classifier package
// Shared types, marker codes and the verdict encoding.
// ----------------------------------------------------------------------------
package jfhc_pkg;

    localparam int QueueDepth = 4;

    localparam logic [7:0] MarkPrefix = 8'hFF;
    localparam logic [7:0] MarkSoi    = 8'hD8;
    localparam logic [7:0] MarkEoi    = 8'hD9;
    localparam logic [7:0] MarkSos    = 8'hDA;
    localparam logic [7:0] MarkSof0   = 8'hC0;
    localparam logic [7:0] MarkSof2   = 8'hC2;
    localparam logic [7:0] MarkTem    = 8'h01;
    localparam logic [7:0] MarkRst0   = 8'hD0;
    localparam logic [7:0] MarkStuff  = 8'h00;
    localparam logic [7:0] MarkDht    = 8'hC4;
    localparam logic [7:0] MarkJpg    = 8'hC8;
    localparam logic [7:0] MarkDac    = 8'hCC;

    localparam logic [15:0] MinSegLen   = 16'd2;
    localparam logic [15:0] MinFrameLen = 16'd8;

    typedef enum logic [3:0] {
        PH_SOI0    = 4'd0,
        PH_SOI1    = 4'd1,
        PH_SCAN    = 4'd2,
        PH_MARK    = 4'd3,
        PH_LEN_HI  = 4'd4,
        PH_LEN_LO  = 4'd5,
        PH_SKIP    = 4'd6,
        PH_FLEN_HI = 4'd7,
        PH_FLEN_LO = 4'd8,
        PH_PREC    = 4'd9,
        PH_H_HI    = 4'd10,
        PH_H_LO    = 4'd11,
        PH_W_HI    = 4'd12,
        PH_W_LO    = 4'd13,
        PH_DONE    = 4'd14
    } t_phase;

    typedef enum logic [2:0] {
        V_NOTJPEG = 3'd0,
        V_BASE    = 3'd1,
        V_PROG    = 3'd2,
        V_UNSUP   = 3'd3,
        V_CORRUPT = 3'd4
    } t_verdict;

    typedef struct packed {
        t_verdict    verdict;
        logic [15:0] width;
        logic [15:0] height;
    } t_result;

    function automatic logic is_standalone(input logic [7:0] m);
        return (m == MarkTem) || ((m >= MarkRst0) && (m <= MarkEoi));
    endfunction

    function automatic logic is_frame(input logic [7:0] m);
        return (m[7:4] == MarkSof0[7:4]) && (m != MarkDht) && (m != MarkJpg)
            && (m != MarkDac);
    endfunction

endpackage
`default_nettype wire

### rtl/core/jfhc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// JPEG frame header classifier channels
// Byte input channel and verdict output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface jfhc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface jfhc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  verdict;
    logic [15:0] image_width;
    logic [15:0] image_height;

    modport source (output valid, output verdict, output image_width,
                    output image_height, input ready);
    modport sink   (input valid, input verdict, input image_width,
                    input image_height, output ready);
endinterface
`default_nettype wire

### rtl/core/jfhc_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// JPEG frame header classifier parser
// Marker segment state machine: one byte per cycle while bytes are accepted, one verdict per file.
// ----------------------------------------------------------------------------
module jfhc_parser
    import jfhc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_last_byte,
    output logic            o_push,
    output t_result         o_result
);

    t_phase      r_phase, n_phase, s_phase;
    logic [7:0]  r_marker, n_marker;
    logic [7:0]  r_len_hi, n_len_hi;
    logic [15:0] r_skip, n_skip;
    logic [15:0] r_height, n_height;
    logic [7:0]  r_width_hi, n_width_hi;
    logic        s_emit;
    t_verdict    s_verdict;
    logic [15:0] s_len;
    logic [15:0] s_width;
    logic        s_dims;

    assign s_len   = {r_len_hi, i_data_byte};
    assign s_width = {r_width_hi, i_data_byte};

    // Byte decode: the step the current phase takes on this byte.
    always_comb begin
        s_phase    = r_phase;
        s_emit     = 1'b0;
        s_verdict  = V_CORRUPT;
        s_dims     = 1'b0;
        n_marker   = r_marker;
        n_len_hi   = r_len_hi;
        n_skip     = r_skip;
        n_height   = r_height;
        n_width_hi = r_width_hi;
        unique case (r_phase)
            PH_DONE: begin
            end
            PH_SOI0: begin
                n_marker = i_data_byte;
                s_phase  = PH_SOI1;
            end
            PH_SOI1: begin
                if (r_marker != MarkPrefix || i_data_byte != MarkSoi) begin
                    s_emit    = 1'b1;
                    s_verdict = V_NOTJPEG;
                end else begin
                    s_phase = PH_SCAN;
                end
            end
            PH_MARK: begin
                if (i_data_byte == MarkPrefix) begin
                    s_phase = PH_MARK;
                end else if (i_data_byte == MarkStuff) begin
                    s_phase = PH_SCAN;
                end else if (i_data_byte == MarkEoi || i_data_byte == MarkSos) begin
                    s_emit    = 1'b1;
                    s_verdict = V_UNSUP;
                end else if (is_standalone(i_data_byte)) begin
                    s_phase = PH_SCAN;
                end else if (is_frame(i_data_byte)) begin
                    n_marker = i_data_byte;
                    s_phase  = PH_FLEN_HI;
                end else begin
                    s_phase = PH_LEN_HI;
                end
            end
            PH_LEN_HI, PH_FLEN_HI: begin
                n_len_hi = i_data_byte;
                s_phase  = (r_phase == PH_LEN_HI) ? PH_LEN_LO : PH_FLEN_LO;
            end
            PH_LEN_LO: begin
                if (s_len < MinSegLen) begin
                    s_emit = 1'b1;
                end else if (s_len == MinSegLen) begin
                    s_phase = PH_SCAN;
                end else begin
                    n_skip  = s_len - MinSegLen;
                    s_phase = PH_SKIP;
                end
            end
            PH_SKIP: begin
                n_skip = r_skip - 16'd1;
                if (r_skip == 16'd1) begin
                    s_phase = PH_SCAN;
                end
            end
            PH_FLEN_LO: begin
                if (s_len < MinFrameLen) begin
                    s_emit = 1'b1;
                end else begin
                    s_phase = PH_PREC;
                end
            end
            PH_PREC: begin
                s_phase = PH_H_HI;
            end
            PH_H_HI: begin
                n_height = {i_data_byte, 8'h00};
                s_phase  = PH_H_LO;
            end
            PH_H_LO: begin
                n_height = {r_height[15:8], i_data_byte};
                s_phase  = PH_W_HI;
            end
            PH_W_HI: begin
                n_width_hi = i_data_byte;
                s_phase    = PH_W_LO;
            end
            PH_W_LO: begin
                s_emit = 1'b1;
                if (s_width != 16'd0 && r_height != 16'd0) begin
                    s_dims = 1'b1;
                    if (r_marker == MarkSof0) begin
                        s_verdict = V_BASE;
                    end else if (r_marker == MarkSof2) begin
                        s_verdict = V_PROG;
                    end else begin
                        s_verdict = V_UNSUP;
                    end
                end
            end
            default: begin
                s_phase = (i_data_byte == MarkPrefix) ? PH_MARK : PH_SCAN;
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_phase = r_phase;
        if (i_accept) begin
            if (i_last_byte) begin
                n_phase = PH_SOI0;
            end else if (s_emit) begin
                n_phase = PH_DONE;
            end else begin
                n_phase = s_phase;
            end
        end
    end

    // Outputs.
    always_comb begin
        o_push          = 1'b0;
        o_result.verdict = s_verdict;
        o_result.width  = s_dims ? s_width : 16'd0;
        o_result.height = s_dims ? r_height : 16'd0;
        if (i_accept && r_phase != PH_DONE) begin
            o_push = s_emit || i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last_byte)) begin
            r_phase    <= PH_SOI0;
            r_marker   <= 8'h00;
            r_len_hi   <= 8'h00;
            r_skip     <= 16'd0;
            r_height   <= 16'd0;
            r_width_hi <= 8'h00;
        end else begin
            r_phase <= n_phase;
            if (i_accept) begin
                r_marker   <= n_marker;
                r_len_hi   <= n_len_hi;
                r_skip     <= n_skip;
                r_height   <= n_height;
                r_width_hi <= n_width_hi;
            end
        end
    end

endmodule
`default_nettype wire

### rtl/core/jfhc_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// JPEG frame header classifier result queue
// Short queue with a registered output stage towards the result channel.
// ----------------------------------------------------------------------------
module jfhc_queue
    import jfhc_pkg::*;
#(
    parameter int DEPTH = QueueDepth
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_result,
    output logic         o_space,
    input  wire logic    i_out_ready,
    output logic         o_out_valid,
    output t_result      o_out_result
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LastAddr = AW'(DEPTH - 1);

    t_result       r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;
    logic          r_valid, n_valid;
    t_result       r_out;
    logic          s_pop;

    assign o_space      = (r_count != CW'(DEPTH));
    assign s_pop        = (r_count != '0) && (!r_valid || i_out_ready);
    assign o_out_valid  = r_valid;
    assign o_out_result = r_out;

    always_comb begin
        n_wr    = (i_push) ? ((r_wr == LastAddr) ? '0 : r_wr + 1'b1) : r_wr;
        n_rd    = (s_pop) ? ((r_rd == LastAddr) ? '0 : r_rd + 1'b1) : r_rd;
        n_count = r_count + CW'(i_push) - CW'(s_pop);
        n_valid = s_pop || (r_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_result;
        end
        if (s_pop) begin
            r_out <= r_mem[r_rd];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

endmodule
`default_nettype wire

### rtl/core/jpeg_frame_header_classifier_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// JPEG frame header classifier core
// Reads a JPEG file one byte per beat and reports its frame type and size.
//
// The byte channel carries data_byte and last_byte, one byte of the file per
// beat, with last_byte set on the final byte. The result channel carries one
// beat per file: the verdict and, when a start-of-frame gave it, the image
// width and height. A verdict goes from the parser into the queue memory
// and then into the registered output stage; bytes after a verdict produce
// nothing until the last byte, which rearms the parser for the next file.
// A new byte is taken every cycle while the queue has space. The parser
// writes verdicts into a queue of QUEUE_DEPTH entries ahead of a registered
// output stage; the byte channel drops ready only while that queue is full, so
// a stalled receiver holds the input back only once several verdicts are waiting.
// Synchronous reset clears the parser to expect a start-of-image marker and
// empties the queue; no results are pending after reset.
// ----------------------------------------------------------------------------
module jpeg_frame_header_classifier_core
    import jfhc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepth
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    jfhc_in_if.sink      i_byte,
    jfhc_out_if.source   o_result
);

    logic    s_accept;
    logic    s_push;
    logic    s_space;
    t_result s_result;
    t_result s_out;

    assign i_byte.ready = s_space;
    assign s_accept     = i_byte.valid && s_space;

    jfhc_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (s_accept),
        .i_data_byte (i_byte.data_byte),
        .i_last_byte (i_byte.last_byte),
        .o_push      (s_push),
        .o_result    (s_result)
    );

    jfhc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (s_push),
        .i_result     (s_result),
        .o_space      (s_space),
        .i_out_ready  (o_result.ready),
        .o_out_valid  (o_result.valid),
        .o_out_result (s_out)
    );

    assign o_result.verdict      = s_out.verdict;
    assign o_result.image_width  = s_out.width;
    assign o_result.image_height = s_out.height;

endmodule
`default_nettype wire

### verif/tb_jpeg_frame_header_classifier_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// JPEG frame header classifier core testbench
// Sends byte streams into the core and checks every verdict beat against a
// behavioural parser held in the testbench or a table's fixed result. A short
// table of hand-built files comes first, then a backpressure burst, then
// randomly built files under several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_jpeg_frame_header_classifier_core;
    import jfhc_pkg::*;

    localparam int StallLimit    = 5000;
    localparam int DrainCycles   = 10;
    localparam int HoldCycles    = 400;
    localparam int BytesPerPhase = 400;
    localparam logic [7:0] MarkSof15 = 8'hCF;
    localparam logic [7:0] SegMarkers [8] = '{8'hE0, 8'hE1, 8'hEF, 8'hDB,
                                              8'hC4, 8'hC8, 8'hCC, 8'hFE};
    localparam int GapPcts   [4] = '{0, 75, 0, 20};
    localparam int StallPcts [4] = '{0, 0, 75, 20};

    typedef struct {
        logic [7:0]  data;
        bit          last;
        bit          fixed_res;
        t_verdict    verdict;
        logic [15:0] width;
        logic [15:0] height;
    } t_hdr_row;

    localparam int HdrRows = 25;
    t_hdr_row hdr_rows [HdrRows] = '{
        '{8'h00, 1'b1, 1'b1, V_CORRUPT, 16'h0000, 16'h0000},
        '{8'hFF, 1'b0, 1'b0, V_NOTJPEG, 16'h0000, 16'h0000},
        '{8'hD8, 1'b0, 1'b0, V_NOTJPEG, 16'h0000, 16'h0000},
        '{8'hFF, 1'b0, 1'b0, V_NOTJPEG, 16'h0000, 16'h0000},
        '{8'hC0, 1'b0, 1'b0, V_NOTJPEG, 16'h0000, 16'h0000},
        '{8'h00, 1'b0, 1'b0, V_NOTJPEG, 16'h0000, 16'h0000},
        '{8'h08, 1'b0, 1'b0, V_NOTJPEG, 16'h0000, 16'h0000},
        '{8'h08, 1'b0, 1'b0, V_NOTJPEG, 16'h0000, 16'h0000},
        '{8'hFF, 1'b0, 1'b0, V_NOTJPEG, 16'h0000, 16'h0000},
        '{8'hFF, 1'b0, 1'b0, V_NOTJPEG, 16'h0000, 16'h0000},
        '{8'hFF, 1'b0, 1'b0, V_NOTJPEG, 16'h0000, 16'h0000},
        '{8'hFF, 1'b1, 1'b1, V_BASE,    16'hFFFF, 16'hFFFF},
        '{8'h12, 1'b0, 1'b0, V_NOTJPEG, 16'h0000, 16'h0000},
        '{8'h34, 1'b1, 1'b1, V_NOTJPEG, 16'h0000, 16'h0000},
        '{8'hFF, 1'b0, 1'b0, V_NOTJPEG, 16'h0000, 16'h0000},
        '{8'hD8, 1'b0, 1'b0, V_NOTJPEG, 16'h0000, 16'h0000},
        '{8'hFF, 1'b0, 1'b0, V_NOTJPEG, 16'h0000, 16'h0000},
        '{8'hDA, 1'b1, 1'b1, V_UNSUP,   16'h0000, 16'h0000},
        '{8'hFF, 1'b0, 1'b0, V_NOTJPEG, 16'h0000, 16'h0000},
        '{8'hD8, 1'b0, 1'b0, V_NOTJPEG, 16'h0000, 16'h0000},
        '{8'hFF, 1'b0, 1'b0, V_NOTJPEG, 16'h0000, 16'h0000},
        '{8'hC1, 1'b0, 1'b0, V_NOTJPEG, 16'h0000, 16'h0000},
        '{8'h00, 1'b0, 1'b0, V_NOTJPEG, 16'h0000, 16'h0000},
        '{8'h07, 1'b1, 1'b1, V_CORRUPT, 16'h0000, 16'h0000},
        '{8'hFF, 1'b1, 1'b0, V_NOTJPEG, 16'h0000, 16'h0000}
    };

    logic i_clk;
    logic i_rst_n;

    jfhc_in_if  byte_if ();
    jfhc_out_if res_if ();

    jpeg_frame_header_classifier_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (byte_if),
        .o_result (res_if)
    );

    t_phase      prs_phase    = PH_SOI0;
    logic [7:0]  sof_mark     = 8'h00;
    logic [7:0]  len_hi       = 8'h00;
    logic [15:0] skip_left    = 16'h0000;
    logic [15:0] hgt_seen     = 16'h0000;
    logic [7:0]  wid_hi       = 8'h00;
    bit          verdict_done = 1'b0;

    t_result    pending_verdicts [$];
    logic [7:0] file_bytes [$];
    int         err_cnt        = 0;
    int         send_gap_pct   = 0;
    int         recv_stall_pct = 0;
    int         hold_reqs      = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        err_cnt++;
    endtask

    function automatic void predict_verdict(input logic [7:0] b, input bit lst,
                                            output bit got, output t_result r);
        logic [15:0] seg_len;
        got = 1'b0;
        r = '0;
        r.verdict = V_CORRUPT;
        if (!verdict_done) begin
            case (prs_phase)
                PH_SOI0: begin
                    sof_mark  = b;
                    prs_phase = PH_SOI1;
                end
                PH_SOI1: begin
                    if (sof_mark != MarkPrefix || b != MarkSoi) begin
                        got = 1'b1;
                        r.verdict = V_NOTJPEG;
                    end else begin
                        prs_phase = PH_SCAN;
                    end
                end
                PH_MARK: begin
                    if (b == MarkPrefix) begin
                        prs_phase = PH_MARK;
                    end else if (b == MarkStuff) begin
                        prs_phase = PH_SCAN;
                    end else if (b == MarkEoi || b == MarkSos) begin
                        got = 1'b1;
                        r.verdict = V_UNSUP;
                    end else if (b == MarkTem || (b >= MarkRst0 && b <= MarkEoi)) begin
                        prs_phase = PH_SCAN;
                    end else if (b >= MarkSof0 && b <= MarkSof15 && b != MarkDht
                                 && b != MarkJpg && b != MarkDac) begin
                        sof_mark  = b;
                        prs_phase = PH_FLEN_HI;
                    end else begin
                        prs_phase = PH_LEN_HI;
                    end
                end
                PH_LEN_HI: begin
                    len_hi    = b;
                    prs_phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    seg_len = {len_hi, b};
                    if (seg_len < MinSegLen) begin
                        got = 1'b1;
                    end else if (seg_len == MinSegLen) begin
                        prs_phase = PH_SCAN;
                    end else begin
                        skip_left = seg_len - MinSegLen;
                        prs_phase = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    skip_left = skip_left - 16'd1;
                    if (skip_left == 16'd0) begin
                        prs_phase = PH_SCAN;
                    end
                end
                PH_FLEN_HI: begin
                    len_hi    = b;
                    prs_phase = PH_FLEN_LO;
                end
                PH_FLEN_LO: begin
                    if ({len_hi, b} < MinFrameLen) begin
                        got = 1'b1;
                    end else begin
                        prs_phase = PH_PREC;
                    end
                end
                PH_PREC: prs_phase = PH_H_HI;
                PH_H_HI: begin
                    hgt_seen  = {b, 8'h00};
                    prs_phase = PH_H_LO;
                end
                PH_H_LO: begin
                    hgt_seen  = hgt_seen | {8'h00, b};
                    prs_phase = PH_W_HI;
                end
                PH_W_HI: begin
                    wid_hi    = b;
                    prs_phase = PH_W_LO;
                end
                PH_W_LO: begin
                    got = 1'b1;
                    if ({wid_hi, b} != 16'd0 && hgt_seen != 16'd0) begin
                        r.width  = {wid_hi, b};
                        r.height = hgt_seen;
                        if (sof_mark == MarkSof0) begin
                            r.verdict = V_BASE;
                        end else if (sof_mark == MarkSof2) begin
                            r.verdict = V_PROG;
                        end else begin
                            r.verdict = V_UNSUP;
                        end
                    end
                end
                default: prs_phase = (b == MarkPrefix) ? PH_MARK : PH_SCAN;
            endcase
            if (lst) begin
                got = 1'b1;
            end
            if (got) begin
                verdict_done = 1'b1;
                prs_phase    = PH_DONE;
            end
        end
        if (lst) begin
            prs_phase    = PH_SOI0;
            sof_mark     = 8'h00;
            len_hi       = 8'h00;
            skip_left    = 16'h0000;
            hgt_seen     = 16'h0000;
            wid_hi       = 8'h00;
            verdict_done = 1'b0;
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit lst,
                             output bit got, output t_result r);
        @(negedge i_clk);
        while ($urandom_range(99) < send_gap_pct) begin
            byte_if.valid = 1'b0;
            @(negedge i_clk);
        end
        byte_if.valid     = 1'b1;
        byte_if.data_byte = b;
        byte_if.last_byte = lst;
        do @(posedge i_clk); while (!byte_if.ready);
        predict_verdict(b, lst, got, r);
    endtask

    task automatic send_file();
        bit      got;
        t_result r;
        foreach (file_bytes[i]) begin
            send_byte(file_bytes[i], i == file_bytes.size() - 1, got, r);
            if (got) begin
                pending_verdicts.push_back(r);
            end
        end
    endtask

    task automatic settle();
        @(negedge i_clk);
        byte_if.valid = 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_dim();
        int roll;
        roll = $urandom_range(99);
        if (roll < 8) begin
            return 16'd0;
        end else if (roll < 16) begin
            return 16'($urandom);
        end
        return 16'($urandom_range(1, 4000));
    endfunction

    task automatic build_file();
        int          roll;
        int          seg_len;
        int          cut;
        logic [7:0]  mk;
        logic [15:0] dim;
        file_bytes.delete();
        if ($urandom_range(99) < 8) begin
            repeat ($urandom_range(1, 12)) file_bytes.push_back(8'($urandom));
        end else begin
            file_bytes.push_back($urandom_range(99) < 4 ? 8'($urandom) : MarkPrefix);
            file_bytes.push_back($urandom_range(99) < 4 ? 8'($urandom) : MarkSoi);
            repeat ($urandom_range(0, 3)) begin
                roll = $urandom_range(0, 9);
                if (roll == 0) begin
                    file_bytes.push_back(MarkPrefix);
                    file_bytes.push_back(MarkPrefix);
                    file_bytes.push_back(MarkTem);
                end else if (roll == 1) begin
                    file_bytes.push_back(MarkPrefix);
                    file_bytes.push_back(MarkRst0 + 8'($urandom_range(0, 7)));
                end else if (roll == 2) begin
                    file_bytes.push_back(MarkPrefix);
                    file_bytes.push_back(MarkStuff);
                end else if (roll == 3) begin
                    file_bytes.push_back(8'($urandom_range(0, 254)));
                end else begin
                    file_bytes.push_back(MarkPrefix);
                    if ($urandom_range(99) < 5) begin
                        file_bytes.push_back(8'($urandom));
                    end else begin
                        file_bytes.push_back(SegMarkers[$urandom_range(0, 7)]);
                    end
                    roll = $urandom_range(99);
                    if (roll < 5) begin
                        seg_len = $urandom_range(0, 1);
                    end else if (roll < 8) begin
                        seg_len = $urandom_range(200, 300);
                    end else begin
                        seg_len = $urandom_range(2, 10);
                    end
                    file_bytes.push_back(8'(seg_len >> 8));
                    file_bytes.push_back(8'(seg_len));
                    repeat (seg_len > 2 ? seg_len - 2 : 0) file_bytes.push_back(8'($urandom));
                end
            end
            roll = $urandom_range(99);
            if (roll < 75) begin
                roll = $urandom_range(99);
                if (roll < 40) begin
                    mk = MarkSof0;
                end else if (roll < 70) begin
                    mk = MarkSof2;
                end else begin
                    mk = MarkSof0 | 8'($urandom_range(0, 15));
                end
                file_bytes.push_back(MarkPrefix);
                file_bytes.push_back(mk);
                seg_len = ($urandom_range(99) < 90) ? $urandom_range(8, 17)
                                                    : $urandom_range(0, 7);
                file_bytes.push_back(8'(seg_len >> 8));
                file_bytes.push_back(8'(seg_len));
                file_bytes.push_back(8'($urandom));
                dim = pick_dim();
                file_bytes.push_back(dim[15:8]);
                file_bytes.push_back(dim[7:0]);
                dim = pick_dim();
                file_bytes.push_back(dim[15:8]);
                file_bytes.push_back(dim[7:0]);
            end else if (roll < 85) begin
                file_bytes.push_back(MarkPrefix);
                file_bytes.push_back($urandom_range(1) ? MarkEoi : MarkSos);
            end
            repeat ($urandom_range(0, 4)) file_bytes.push_back(8'($urandom));
            if ($urandom_range(99) < 10) begin
                cut = $urandom_range(1, file_bytes.size());
                while (file_bytes.size() > cut) void'(file_bytes.pop_back());
            end
        end
    endtask

    // The receiver side, including the long hold-off that lets the verdict
    // queue fill and back up into the byte channel.
    initial begin
        int hold_left;
        int hold_served;
        hold_left     = 0;
        hold_served   = 0;
        res_if.ready  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_served != hold_reqs) begin
                hold_served++;
                hold_left = HoldCycles;
            end
            if (hold_left > 0) begin
                res_if.ready = 1'b0;
                hold_left--;
            end else begin
                res_if.ready = i_rst_n && ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_result exp_res;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch($sformatf("verdict beat with nothing expected: %0d %0d %0d",
                                          res_if.verdict, res_if.image_width,
                                          res_if.image_height));
            end else begin
                exp_res = pending_verdicts.pop_front();
                if (res_if.verdict !== exp_res.verdict) begin
                    report_mismatch($sformatf("verdict %0d, expected %s",
                                              res_if.verdict, exp_res.verdict.name()));
                end
                if (res_if.image_width !== exp_res.width) begin
                    report_mismatch($sformatf("width %0d, expected %0d",
                                              res_if.image_width, exp_res.width));
                end
                if (res_if.image_height !== exp_res.height) begin
                    report_mismatch($sformatf("height %0d, expected %0d",
                                              res_if.image_height, exp_res.height));
                end
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < StallLimit) begin
            @(posedge i_clk);
            if (!i_rst_n || (byte_if.valid && byte_if.ready)
                    || (res_if.valid && res_if.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        bit      got;
        t_result r;
        int      sent;
        byte_if.valid     = 1'b0;
        byte_if.data_byte = 8'h00;
        byte_if.last_byte = 1'b0;
        i_rst_n           = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (hdr_rows[i]) begin
            send_byte(hdr_rows[i].data, hdr_rows[i].last, got, r);
            if (hdr_rows[i].fixed_res) begin
                pending_verdicts.push_back({hdr_rows[i].verdict, hdr_rows[i].width,
                                            hdr_rows[i].height});
            end else if (got) begin
                pending_verdicts.push_back(r);
            end
        end
        settle();

        // Two-byte files that fail the start-of-image check give one verdict
        // each, so the stalled receiver soon backs the core up.
        hold_reqs++;
        repeat (12) begin
            file_bytes.delete();
            file_bytes.push_back(8'($urandom_range(0, 254)));
            file_bytes.push_back(8'($urandom));
            send_file();
        end
        settle();

        for (int p = 0; p < 4; p++) begin
            send_gap_pct   = GapPcts[p];
            recv_stall_pct = StallPcts[p];
            sent = 0;
            while (sent < BytesPerPhase) begin
                build_file();
                sent += file_bytes.size();
                send_file();
            end
            settle();
        end

        if (pending_verdicts.size() != 0) begin
            report_mismatch($sformatf("%0d verdicts never arrived", pending_verdicts.size()));
        end
        if (err_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
